/* design/cbm_pkg.sv */
package cbm_pkg;

    // field widths
    localparam int DATA_W    = 8;
    localparam int BANK_W    = 8;
    localparam int OFFSET_W  = 16;
    localparam int ROM_IDX_W = 23;
    localparam int RAM_IDX_W = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 23;

    // decode boundaries
    localparam logic [BANK_W-1:0]   LO_RAM_BANK_LO  = 8'h70;
    localparam logic [BANK_W-1:0]   LO_RAM_BANK_END = 8'h7e;
    localparam logic [BANK_W-1:0]   LO_RAM_BANK_TOP = 8'hf0;
    localparam logic [OFFSET_W-1:0] ROM_WINDOW      = 16'h8000;
    localparam logic [OFFSET_W-1:0] HI_RAM_BASE     = 16'h6000;
    localparam logic [6:0]          ROM_BANK_MIN    = 7'h40;

    typedef enum logic [1:0] {
        ACT_READ     = 2'd0,
        ACT_WRITE    = 2'd1,
        ACT_ROM_FILL = 2'd2,
        ACT_RAM_FILL = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_LO   = 2'd1,
        MODE_HI   = 2'd2,
        MODE_EX   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_ROM  = 2'd1,
        SRC_RAM  = 2'd2
    } t_source;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 2'd0,
        CFG_ROM_MASK    = 2'd1,
        CFG_RAM_MASK    = 2'd2,
        CFG_RAM_PRESENT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        t_mode                mode;
        logic [ROM_IDX_W-1:0] rom_mask;
        logic [RAM_IDX_W-1:0] ram_mask;
        logic                 ram_present;
    } t_cfg;

    typedef struct packed {
        t_source              src;
        logic [ROM_IDX_W-1:0] rom_idx;
        logic [RAM_IDX_W-1:0] ram_idx;
    } t_decode;

endpackage

/* design/cartridge_bank_mapper_top.sv */
// latency: a result strobes on o_valid in the cycle after its beat is accepted
// throughput: one beat per cycle while busy is low, set by the single port of each store
// busy is high during reset and in the first cycle after it, then stays low
// reset (synchronous, active low) clears the config registers to zero
// rom and ram contents are not cleared; an unwritten entry reads undefined
// results cannot be stalled: o_valid lasts exactly one cycle per beat
module cartridge_bank_mapper_top #(
    parameter int ROM_ADDR_BITS = 22,
    parameter int RAM_ADDR_BITS = 17
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_action,
    input  logic [cbm_pkg::BANK_W-1:0]        i_bank,
    input  logic [cbm_pkg::OFFSET_W-1:0]      i_offset,
    input  logic [cbm_pkg::DATA_W-1:0]        i_write_byte,
    input  logic [cbm_pkg::ROM_IDX_W-1:0]     i_fill_index,
    input  logic [cbm_pkg::DATA_W-1:0]        i_open_bus_value,
    output logic                              o_valid,
    output logic [cbm_pkg::DATA_W-1:0]        o_read_byte,
    output logic [1:0]                        o_source,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    cbm_pkg::t_cfg    r_cfg;
    cbm_pkg::t_decode w_dec;
    cbm_pkg::t_source r_src;
    cbm_pkg::t_source n_src;
    logic [cbm_pkg::DATA_W-1:0] r_obus;
    logic [cbm_pkg::DATA_W-1:0] n_obus;
    logic r_valid;
    logic r_busy;
    logic r_is_read;
    logic w_accept;

    logic [cbm_pkg::ROM_IDX_W-1:0] w_rom_masked;
    logic [cbm_pkg::RAM_IDX_W-1:0] w_ram_masked;
    logic                     w_rom_we;
    logic                     w_rom_re;
    logic [ROM_ADDR_BITS-1:0] w_rom_addr;
    logic                     w_ram_we;
    logic                     w_ram_re;
    logic [RAM_ADDR_BITS-1:0] w_ram_addr;
    logic [cbm_pkg::DATA_W-1:0] w_rom_rdata;
    logic [cbm_pkg::DATA_W-1:0] w_ram_rdata;

    assign w_accept    = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (cbm_pkg::t_cfg_index'(i_cfg_index))
                cbm_pkg::CFG_MODE:
                    r_cfg.mode <= cbm_pkg::t_mode'(i_cfg_data[1:0]);
                cbm_pkg::CFG_ROM_MASK:
                    r_cfg.rom_mask <= i_cfg_data[cbm_pkg::ROM_IDX_W-1:0];
                cbm_pkg::CFG_RAM_MASK:
                    r_cfg.ram_mask <= i_cfg_data[cbm_pkg::RAM_IDX_W-1:0];
                cbm_pkg::CFG_RAM_PRESENT:
                    r_cfg.ram_present <= i_cfg_data[0];
            endcase
        end
    end

    // bus address decode
    cbm_decode u_decode (
        .i_cfg    (r_cfg),
        .i_bank   (i_bank),
        .i_offset (i_offset),
        .o_dec    (w_dec)
    );

    // size masks, then wrap to the physical depth
    assign w_rom_masked = w_dec.rom_idx & r_cfg.rom_mask;
    assign w_ram_masked = w_dec.ram_idx & r_cfg.ram_mask;

    // store port control and next result state
    always_comb begin
        w_rom_we   = 1'b0;
        w_rom_re   = 1'b0;
        w_ram_we   = 1'b0;
        w_ram_re   = 1'b0;
        w_rom_addr = w_rom_masked[ROM_ADDR_BITS-1:0];
        w_ram_addr = w_ram_masked[RAM_ADDR_BITS-1:0];
        n_src      = cbm_pkg::SRC_NONE;
        n_obus     = '0;
        unique case (cbm_pkg::t_action'(i_action))
            cbm_pkg::ACT_READ: begin
                w_rom_re = w_accept && (w_dec.src == cbm_pkg::SRC_ROM);
                w_ram_re = w_accept && (w_dec.src == cbm_pkg::SRC_RAM);
                n_src    = w_dec.src;
                n_obus   = i_open_bus_value;
            end
            cbm_pkg::ACT_WRITE: begin
                w_ram_we = w_accept && (w_dec.src == cbm_pkg::SRC_RAM);
            end
            cbm_pkg::ACT_ROM_FILL: begin
                w_rom_we   = w_accept;
                w_rom_addr = i_fill_index[ROM_ADDR_BITS-1:0];
            end
            cbm_pkg::ACT_RAM_FILL: begin
                w_ram_we   = w_accept;
                w_ram_addr = i_fill_index[RAM_ADDR_BITS-1:0];
            end
        endcase
    end

    cbm_store #(
        .ADDR_W (ROM_ADDR_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (w_rom_we),
        .i_re    (w_rom_re),
        .i_addr  (w_rom_addr),
        .i_wdata (i_write_byte),
        .o_rdata (w_rom_rdata)
    );

    cbm_store #(
        .ADDR_W (RAM_ADDR_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (i_write_byte),
        .o_rdata (w_ram_rdata)
    );

    // result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_busy    <= 1'b1;
            r_is_read <= 1'b0;
            r_src     <= cbm_pkg::SRC_NONE;
        end else begin
            r_valid   <= w_accept;
            r_busy    <= 1'b0;
            r_is_read <= (cbm_pkg::t_action'(i_action) == cbm_pkg::ACT_READ);
            r_src     <= n_src;
        end
    end

    // open bus byte, payload only
    always_ff @(posedge i_clk) begin
        r_obus <= n_obus;
    end

    // result beat
    assign o_valid  = r_valid;
    assign o_source = r_src;
    always_comb begin
        priority if (r_src == cbm_pkg::SRC_ROM) begin
            o_read_byte = w_rom_rdata;
        end else if (r_src == cbm_pkg::SRC_RAM) begin
            o_read_byte = w_ram_rdata;
        end else begin
            o_read_byte = r_obus;
        end
    end

`ifndef SYNTHESIS
    a_one_beat_per_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted beat produced no result");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_valid)
        else $error("result without an accepted beat");

    a_write_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_is_read) |-> (o_read_byte == '0 && o_source == cbm_pkg::SRC_NONE))
        else $error("write or fill result not zero");

    a_open_bus_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_is_read && o_source == cbm_pkg::SRC_NONE)
        |-> (o_read_byte == $past(i_open_bus_value)))
        else $error("unmapped read lost the open bus byte");

    a_source_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_source != 2'd3))
        else $error("illegal result source");
`endif

endmodule

/* design/cbm_decode.sv */
module cbm_decode (
    input  cbm_pkg::t_cfg                   i_cfg,
    input  logic [cbm_pkg::BANK_W-1:0]      i_bank,
    input  logic [cbm_pkg::OFFSET_W-1:0]    i_offset,
    output cbm_pkg::t_decode                o_dec
);

    logic [6:0] w_b7;
    logic       w_lo_ram_bank;
    logic       w_lo_ram_hit;
    logic       w_hi_ram_hit;
    logic       w_rom_hit;
    logic       w_ex_high;

    assign w_b7 = i_bank[6:0];

    // lorom battery ram banks 70-7d and f0-ff, below the rom window
    assign w_lo_ram_bank = ((i_bank >= cbm_pkg::LO_RAM_BANK_LO)
                            && (i_bank < cbm_pkg::LO_RAM_BANK_END))
                           || (i_bank >= cbm_pkg::LO_RAM_BANK_TOP);
    assign w_lo_ram_hit  = w_lo_ram_bank && (i_offset < cbm_pkg::ROM_WINDOW)
                           && i_cfg.ram_present;

    // hirom ram window 6000-7fff in the low system banks
    assign w_hi_ram_hit  = (w_b7 < cbm_pkg::ROM_BANK_MIN)
                           && (i_offset >= cbm_pkg::HI_RAM_BASE)
                           && (i_offset < cbm_pkg::ROM_WINDOW)
                           && i_cfg.ram_present;

    // rom is the upper half of every bank plus all of banks 40-7f / c0-ff
    assign w_rom_hit     = (i_offset >= cbm_pkg::ROM_WINDOW)
                           || (w_b7 >= cbm_pkg::ROM_BANK_MIN);

    // exhirom puts the lower banks in the upper 4 MiB
    assign w_ex_high     = (i_cfg.mode == cbm_pkg::MODE_EX) && !i_bank[7];

    // mode dependent selection of store and index
    always_comb begin
        o_dec.src     = cbm_pkg::SRC_NONE;
        o_dec.rom_idx = '0;
        o_dec.ram_idx = '0;
        unique case (i_cfg.mode)
            cbm_pkg::MODE_LO: begin
                priority if (w_lo_ram_hit) begin
                    o_dec.src     = cbm_pkg::SRC_RAM;
                    o_dec.ram_idx = {i_bank[3:0], i_offset[14:0]};
                end else if (w_rom_hit) begin
                    o_dec.src     = cbm_pkg::SRC_ROM;
                    o_dec.rom_idx = {1'b0, w_b7, i_offset[14:0]};
                end else begin
                    o_dec.src     = cbm_pkg::SRC_NONE;
                end
            end
            cbm_pkg::MODE_HI, cbm_pkg::MODE_EX: begin
                priority if (w_hi_ram_hit) begin
                    o_dec.src     = cbm_pkg::SRC_RAM;
                    o_dec.ram_idx = {i_bank[5:0], i_offset[12:0]};
                end else if (w_rom_hit) begin
                    o_dec.src     = cbm_pkg::SRC_ROM;
                    o_dec.rom_idx = {w_ex_high, i_bank[5:0], i_offset};
                end else begin
                    o_dec.src     = cbm_pkg::SRC_NONE;
                end
            end
            cbm_pkg::MODE_NONE: begin
                o_dec.src = cbm_pkg::SRC_NONE;
            end
        endcase
    end

endmodule

/* design/cbm_store.sv */
module cbm_store #(
    parameter int ADDR_W = 17
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_addr,
    input  logic [cbm_pkg::DATA_W-1:0] i_wdata,
    output logic [cbm_pkg::DATA_W-1:0] o_rdata
);

    logic [cbm_pkg::DATA_W-1:0] r_mem [2**ADDR_W];
    logic [cbm_pkg::DATA_W-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
